/* src/jvss_pkg.sv */
// Package for the JSON value span scanner: scan phase type, result kind codes
// and the character codes that the scanner decodes. No dependencies.
`timescale 1ns / 1ps

package jvss_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SKIP    = 3'd1,
        PH_STRING  = 3'd2,
        PH_BRACKET = 3'd3,
        PH_SCALAR  = 3'd4
    } phase_t;

    localparam logic [1:0] KIND_STRING = 2'd0;
    localparam logic [1:0] KIND_OBJECT = 2'd1;
    localparam logic [1:0] KIND_ARRAY  = 2'd2;
    localparam logic [1:0] KIND_SCALAR = 2'd3;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

endpackage

/* src/json_value_span_scanner.sv */
// JSON value span scanner, top level: input register, scan state machine and
// result register with stream handshakes. Depends on jvss_pkg.
`timescale 1ns / 1ps

// Usage
// - Slave stream carries one text byte per transaction (tdata) and the
//   start flag (tuser). A transaction with tuser=1 clears the scan state and
//   begins a new value scan with that byte. A zero byte ends the text.
// - Master stream returns exactly one result transaction per input byte:
//   tuser holds done, error and value kind; tdata holds the span length.
//   Before a start, bytes are ignored and report all zeros; after done or
//   error the scanner stays idle until the next start.
// - Registering: a byte is held in the input register, then its result in the
//   result register, which drives the master side (two register stages).
// - Throughput: one byte per cycle while the master side is ready. All per-byte
//   work (space test, quote and escape tracking, depth and length counters) is
//   one combinational pass between the input register and the result register.
// - Stalls: when the master side is not ready, the result register holds;
//   the input register still takes one more byte, then tready drops until
//   the result is taken. Nothing is lost or repeated.
// - Reset (rst_n low, asynchronous): both registers empty, scanner idle,
//   counters and flags cleared.
// - The internal length counter is LENGTH_BITS wide and saturates at its
// maximum with an error; the reported length saturates at 65535. An opening
// bracket of the value's own kind at the maximum depth (2^DEPTH_BITS-1) is an error.
module json_value_span_scanner #(
    parameter int LENGTH_BITS = 16,
    parameter int DEPTH_BITS  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tuser,   // [0] start_req
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] span_length
    output logic [3:0]  m_axis_tuser    // [0] done_res, [1] error, [3:2] value_kind
);

    import jvss_pkg::*;

    localparam int EXT_W = LENGTH_BITS + 16;

    // Input register
    logic       in_valid_reg;
    logic       in_start_reg;
    logic [7:0] in_byte_reg;

    // Scan state
    phase_t                 phase_reg,    phase_next;
    logic                   quotes_reg,   quotes_next;
    logic                   escape_reg,   escape_next;
    logic                   is_array_reg, is_array_next;
    logic [DEPTH_BITS-1:0]  depth_reg,    depth_next;
    logic [LENGTH_BITS-1:0] count_reg,    count_next;

    // Result register
    logic        out_valid_reg;
    logic        out_done_reg;
    logic        out_error_reg;
    logic [1:0]  out_kind_reg;
    logic [15:0] out_len_reg;

    // State as seen by the byte in the input register (start clears it)
    phase_t                 cur_phase;
    logic                   cur_quotes;
    logic                   cur_escape;
    logic                   cur_is_array;
    logic [DEPTH_BITS-1:0]  cur_depth;
    logic [LENGTH_BITS-1:0] cur_count;

    logic       advance;
    logic       b_space;
    logic       b_nul;
    logic       b_closer;
    logic       count_full;
    logic [7:0] open_ch;
    logic [7:0] close_ch;
    logic       ev_done;
    logic       ev_err;
    logic [1:0] res_kind;
    logic [15:0] res_len;
    logic [EXT_W-1:0] count_ext;

    // Pipeline handshake: process the held byte when the result slot frees
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign cur_phase    = in_start_reg ? PH_SKIP : phase_reg;
    assign cur_quotes   = in_start_reg ? 1'b0 : quotes_reg;
    assign cur_escape   = in_start_reg ? 1'b0 : escape_reg;
    assign cur_is_array = in_start_reg ? 1'b0 : is_array_reg;
    assign cur_depth    = in_start_reg ? '0 : depth_reg;
    assign cur_count    = in_start_reg ? '0 : count_reg;

    assign b_nul      = (in_byte_reg == CH_NUL);
    assign b_space    = (in_byte_reg == CH_SPACE) || (in_byte_reg == CH_TAB) ||
                        (in_byte_reg == CH_LF) || (in_byte_reg == CH_CR);
    assign b_closer   = (in_byte_reg == CH_COMMA) || (in_byte_reg == CH_RBRACE) ||
                        (in_byte_reg == CH_RBRACK);
    assign count_full = (cur_count == {LENGTH_BITS{1'b1}});
    assign open_ch    = cur_is_array ? CH_LBRACK : CH_LBRACE;
    assign close_ch   = cur_is_array ? CH_RBRACK : CH_RBRACE;

    // Next state and end-of-scan events
    always_comb
    begin
        phase_next    = cur_phase;
        quotes_next   = cur_quotes;
        escape_next   = cur_escape;
        is_array_next = cur_is_array;
        depth_next    = cur_depth;
        count_next    = cur_count;
        ev_done       = 1'b0;
        ev_err        = 1'b0;
        unique case (cur_phase)
            PH_SKIP:
            begin
                if (b_space)
                begin
                    phase_next = PH_SKIP;
                end
                else if (b_nul || b_closer)
                begin
                    ev_err     = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    count_next = LENGTH_BITS'(1);
                    if (in_byte_reg == CH_QUOTE)
                    begin
                        phase_next = PH_STRING;
                    end
                    else if (in_byte_reg == CH_LBRACE || in_byte_reg == CH_LBRACK)
                    begin
                        is_array_next = (in_byte_reg == CH_LBRACK);
                        depth_next    = DEPTH_BITS'(1);
                        phase_next    = PH_BRACKET;
                    end
                    else
                    begin
                        phase_next = PH_SCALAR;
                    end
                end
            end
            PH_STRING:
            begin
                if (b_nul || count_full)
                begin
                    ev_err     = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    count_next = cur_count + LENGTH_BITS'(1);
                    priority if (cur_escape)
                        escape_next = 1'b0;
                    else if (in_byte_reg == CH_BSLASH)
                        escape_next = 1'b1;
                    else if (in_byte_reg == CH_QUOTE)
                    begin
                        ev_done    = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                        escape_next = cur_escape;
                end
            end
            PH_BRACKET:
            begin
                if (b_nul || count_full)
                begin
                    ev_err     = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    count_next = cur_count + LENGTH_BITS'(1);
                    priority if (cur_quotes)
                    begin
                        priority if (cur_escape)
                            escape_next = 1'b0;
                        else if (in_byte_reg == CH_BSLASH)
                            escape_next = 1'b1;
                        else if (in_byte_reg == CH_QUOTE)
                            quotes_next = 1'b0;
                        else
                            quotes_next = cur_quotes;
                    end
                    else if (in_byte_reg == CH_QUOTE)
                        quotes_next = 1'b1;
                    else if (in_byte_reg == open_ch)
                    begin
                        if (cur_depth == {DEPTH_BITS{1'b1}})
                        begin
                            ev_err     = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else
                            depth_next = cur_depth + DEPTH_BITS'(1);
                    end
                    else if (in_byte_reg == close_ch)
                    begin
                        depth_next = cur_depth - DEPTH_BITS'(1);
                        if (cur_depth == DEPTH_BITS'(1))
                        begin
                            ev_done    = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                    else
                        depth_next = cur_depth;
                end
            end
            PH_SCALAR:
            begin
                if (b_nul || b_closer || b_space)
                begin
                    ev_done    = 1'b1;
                    phase_next = PH_IDLE;
                end
                else if (count_full)
                begin
                    ev_err     = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                    count_next = cur_count + LENGTH_BITS'(1);
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Result fields
    assign count_ext = {16'd0, count_next};

    always_comb
    begin
        res_kind = KIND_STRING;
        if (ev_done || ev_err || phase_next != PH_IDLE)
        begin
            unique case (cur_phase)
                PH_SKIP:
                begin
                    if (b_closer)
                        res_kind = KIND_SCALAR;
                    else if (b_space || b_nul || in_byte_reg == CH_QUOTE)
                        res_kind = KIND_STRING;
                    else if (in_byte_reg == CH_LBRACE)
                        res_kind = KIND_OBJECT;
                    else if (in_byte_reg == CH_LBRACK)
                        res_kind = KIND_ARRAY;
                    else
                        res_kind = KIND_SCALAR;
                end
                PH_STRING:  res_kind = KIND_STRING;
                PH_BRACKET: res_kind = cur_is_array ? KIND_ARRAY : KIND_OBJECT;
                PH_SCALAR:  res_kind = KIND_SCALAR;
                default:    res_kind = KIND_STRING;
            endcase
            if (count_ext > EXT_W'(16'hFFFF))
                res_len = 16'hFFFF;
            else
                res_len = count_ext[15:0];
        end
        else
            res_len = 16'd0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            quotes_reg    <= 1'b0;
            escape_reg    <= 1'b0;
            is_array_reg  <= 1'b0;
            depth_reg     <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                phase_reg    <= phase_next;
                quotes_reg   <= quotes_next;
                escape_reg   <= escape_next;
                is_array_reg <= is_array_next;
                depth_reg    <= depth_next;
                count_reg    <= count_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_start_reg <= s_axis_tuser;
            in_byte_reg  <= s_axis_tdata;
        end
        if (advance)
        begin
            out_done_reg  <= ev_done;
            out_error_reg <= ev_err;
            out_kind_reg  <= res_kind;
            out_len_reg   <= res_len;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_len_reg;
    assign m_axis_tuser  = {out_kind_reg, out_error_reg, out_done_reg};

endmodule
